>>> hw/rtl/iam_pkg.sv
// ----------------------------------------------------------------------------
// Input action mapper package
// Shared constants, command codes and payload types.
// ----------------------------------------------------------------------------
package iam_pkg;

   localparam int BINDINGS = 32;
   localparam int ACTIONS  = 16;
   localparam int MAPS     = 4;

   localparam int BIDX_W = $clog2(BINDINGS);
   localparam int AIDX_W = $clog2(ACTIONS);
   localparam int MIDX_W = $clog2(MAPS);

   typedef enum logic [2:0] {
      CMD_KEY_DOWN = 3'd0,
      CMD_KEY_UP   = 3'd1,
      CMD_MODS     = 3'd2,
      CMD_BTN_DOWN = 3'd3,
      CMD_BTN_UP   = 3'd4,
      CMD_AXIS     = 3'd5,
      CMD_WR_BIND  = 3'd6,
      CMD_WR_MAP   = 3'd7
   } cmd_type;

   localparam logic [2:0] KIND_KEY    = 3'd1;
   localparam logic [2:0] KIND_MOD    = 3'd2;
   localparam logic [2:0] KIND_BUTTON = 3'd3;
   localparam logic [2:0] KIND_AXIS   = 3'd4;

   localparam logic [1:0] EV_FINAL = 2'd0;
   localparam logic [1:0] EV_DOWN  = 2'd1;
   localparam logic [1:0] EV_UP    = 2'd2;

   localparam logic [1:0] CSR_MAP_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_ACTION_COUNT  = 2'd1;
   localparam logic [1:0] CSR_BINDING_COUNT = 2'd2;
   localparam logic [1:0] CSR_MAP_COUNT     = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_SCAN, ST_FINAL
   } state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] code;
      logic [15:0] modifier_mask;
      logic [15:0] vendor_id;
      logic [15:0] product_id;
      logic signed [15:0] axis_value;
      logic signed [15:0] axis_last;
      logic [4:0]  table_index;
      logic [2:0]  binding_kind;
      logic [1:0]  binding_map;
      logic [3:0]  binding_action;
   } req_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [3:0] action;
      logic       handled;
      logic       last;
   } rsp_type;

   // One binding slot as held in a cell
   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] code;
      logic [15:0] mods;
      logic [1:0]  map;
      logic [3:0]  action;
      logic signed [15:0] trig;
      logic signed [15:0] rel;
   } binding_type;

   // Write strobe into the chain
   typedef struct packed {
      logic               we;
      logic [BIDX_W-1:0]  idx;
      binding_type        data;
   } bind_wr_type;

endpackage

>>> hw/rtl/iam_cell.sv
// ----------------------------------------------------------------------------
// Binding cell
// Holds one binding slot; on a shift pulse hands it to its neighbour, so the
// row rotates and each slot passes the chain head in turn.
// ----------------------------------------------------------------------------
module iam_cell (
   input  logic                 clock,
   input  logic                 shift,
   input  logic                 load,
   input  iam_pkg::binding_type load_data,
   input  iam_pkg::binding_type prev_data,
   output iam_pkg::binding_type data
);
   iam_pkg::binding_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = load_data;
      end else if (shift) begin
         data_in = prev_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule

>>> hw/rtl/iam_chain.sv
// ----------------------------------------------------------------------------
// Binding chain
// Row of binding cells rotating once per scan step. A position counter keeps
// track of the rotation so that writes land in the right cell.
// ----------------------------------------------------------------------------
module iam_chain (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  iam_pkg::bind_wr_type wr,
   output iam_pkg::binding_type head
);
   localparam int N = iam_pkg::BINDINGS;
   localparam int W = iam_pkg::BIDX_W;

   iam_pkg::binding_type cell_q [N];
   // rot_ff: slot number currently sitting in cell 0
   logic [W-1:0] rot_ff, rot_in;
   logic [W-1:0] wr_cell;

   always_comb begin
      rot_in = rot_ff;
      if (shift) begin
         rot_in = (rot_ff == W'(N - 1)) ? '0 : rot_ff + W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff <= '0;
      end else begin
         rot_ff <= rot_in;
      end
   end

   // cell c holds slot (rot + c) mod N, so slot s lives in cell (s - rot) mod N
   always_comb begin
      if (wr.idx >= rot_ff) begin
         wr_cell = wr.idx - rot_ff;
      end else begin
         wr_cell = W'(N - 1) - rot_ff + wr.idx + W'(1);
      end
   end

   for (genvar c = 0; c < N; c++) begin : g_cell
      iam_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .load      (wr.we && (wr_cell == W'(c))),
         .load_data (wr.data),
         .prev_data (cell_q[(c + 1) % N]),
         .data      (cell_q[c])
      );
   end

   assign head = cell_q[0];
endmodule

>>> hw/rtl/input_action_mapper_top.sv
// ----------------------------------------------------------------------------
// Input action mapper
// Turns key, modifier, gamepad button and axis events into numbered action
// down/up transfers followed by one final status transfer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/ready    | iam_pkg::req_type
//  rsp     | out | rsp_valid/ready    | iam_pkg::rsp_type
//  csr     | in  | csr_valid/ready    | csr_index, csr_data
//
// Sequence: an event is taken in idle, then goes through an identity search
// (button/axis only; a miss skips the scan), a scan over one rotation of the
// cell row and the final transfer.
// Table writes are taken in idle and leave the sequencer there.
// The scan only advances when the output register is free, so rsp stalls
// hold the sequencer. Reset clears the sequencer, registers, triggered bits
// and previous modifiers; the binding and identity tables are unset.
// ----------------------------------------------------------------------------
module input_action_mapper_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  iam_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output iam_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [5:0]        csr_data
);
   localparam int NB = iam_pkg::BINDINGS;
   localparam int NA = iam_pkg::ACTIONS;
   localparam int NM = iam_pkg::MAPS;
   localparam int BW = iam_pkg::BIDX_W;
   localparam int AW = iam_pkg::AIDX_W;
   localparam int MW = iam_pkg::MIDX_W;

   // configuration registers, saturated on write (action and map counts use only csr_data[4:0] and [2:0])
   logic         en_ff;
   logic [6:0]   nact_ff;
   logic [8:0]   nbind_ff;
   logic [4:0]   nmap_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b0;
         nact_ff  <= '0;
         nbind_ff <= '0;
         nmap_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            iam_pkg::CSR_MAP_ENABLE:    en_ff <= csr_data[0];
            iam_pkg::CSR_ACTION_COUNT:
               nact_ff <= (csr_data[4:0] > 5'(NA)) ? 7'(NA) : 7'(csr_data[4:0]);
            iam_pkg::CSR_BINDING_COUNT:
               nbind_ff <= (csr_data > 6'(NB)) ? 9'(NB) : 9'(csr_data);
            iam_pkg::CSR_MAP_COUNT:
               nmap_ff <= (csr_data[2:0] > 3'(NM)) ? 5'(NM) : 5'(csr_data[2:0]);
            default: ;
         endcase
      end
   end

   // gamepad identity table
   logic [31:0] ids_ff [NM];

   // sequencer state
   iam_pkg::state_type state_ff, state_in;
   iam_pkg::req_type   ev_ff;
   logic [8:0]         step_ff, step_in;     // slot or map counter
   logic [MW-1:0]      map_ff, map_in;
   logic               hand_ff, hand_in;
   logic [15:0]        pmod_ff, pmod_in;
   logic [NA-1:0]      trig_ff, trig_in;
   logic               shift;
   iam_pkg::bind_wr_type wr;
   iam_pkg::binding_type head;

   // output register
   logic             ov_ff, ov_in;
   iam_pkg::rsp_type od_ff, od_in;
   logic             out_free;

   assign out_free = !ov_ff || rsp_ready;
   assign rsp_valid = ov_ff;
   assign rsp_data  = od_ff;
   assign req_ready = (state_ff == iam_pkg::ST_IDLE);

   // binding writes go straight into the chain
   always_comb begin
      wr.we          = req_valid && req_ready && (req_data.cmd == iam_pkg::CMD_WR_BIND)
                       && (32'(req_data.table_index) < 32'(NB));
      wr.idx         = BW'(req_data.table_index);
      wr.data.kind   = req_data.binding_kind;
      wr.data.code   = req_data.code;
      wr.data.mods   = req_data.modifier_mask;
      wr.data.map    = req_data.binding_map;
      wr.data.action = req_data.binding_action;
      wr.data.trig   = req_data.axis_value;
      wr.data.rel    = req_data.axis_last;
   end

   iam_chain u_chain (
      .clock (clock),
      .reset (reset),
      .shift (shift),
      .wr    (wr),
      .head  (head)
   );

   always_ff @(posedge clock) begin
      if (req_valid && req_ready && (req_data.cmd == iam_pkg::CMD_WR_MAP)
          && (32'(req_data.table_index) < 32'(NM))) begin
         ids_ff[MW'(req_data.table_index)] <= {req_data.vendor_id, req_data.product_id};
      end
   end

   // per-binding evaluation of the head cell
   logic        match, down, is_mod, act_ok, do_emit;
   logic [15:0] was_m, now_m;
   logic signed [16:0] lv, nv, tv, rv;
   logic        dir_up, cross_on, cross_off;
   logic [AW-1:0] act_idx;

   always_comb begin
      act_idx = AW'(head.action);
      act_ok  = (7'(head.action) < nact_ff);
      is_mod  = (ev_ff.cmd == iam_pkg::CMD_MODS);
      was_m   = head.mods & pmod_ff;
      now_m   = head.mods & ev_ff.modifier_mask;
      // axis hysteresis: negate everything when direction is down
      dir_up  = (head.trig > head.rel) || ((head.trig == head.rel) && (head.trig > 0));
      lv = dir_up ? 17'(ev_ff.axis_last)  : -17'(ev_ff.axis_last);
      nv = dir_up ? 17'(ev_ff.axis_value) : -17'(ev_ff.axis_value);
      tv = dir_up ? 17'(head.trig) : -17'(head.trig);
      rv = dir_up ? 17'(head.rel)  : -17'(head.rel);
      cross_on  = (lv < tv) && (nv >= tv);
      cross_off = (lv >= rv) && (nv < rv);
      match = 1'b0;
      down  = 1'b0;
      case (ev_ff.cmd)
         iam_pkg::CMD_KEY_DOWN, iam_pkg::CMD_KEY_UP: begin
            match = (head.kind == iam_pkg::KIND_KEY) && (head.code == ev_ff.code);
            down  = (ev_ff.cmd == iam_pkg::CMD_KEY_DOWN);
         end
         iam_pkg::CMD_MODS: begin
            match = (head.kind == iam_pkg::KIND_MOD) && ((was_m != 0) != (now_m != 0));
            down  = (now_m != 0);
         end
         iam_pkg::CMD_BTN_DOWN, iam_pkg::CMD_BTN_UP: begin
            match = (head.kind == iam_pkg::KIND_BUTTON) && (head.code == ev_ff.code)
                    && (MW'(head.map) == map_ff) && (4'(head.map) < 4'(NM));
            down  = (ev_ff.cmd == iam_pkg::CMD_BTN_DOWN);
         end
         iam_pkg::CMD_AXIS: begin
            match = (head.kind == iam_pkg::KIND_AXIS) && (head.code == ev_ff.code)
                    && (MW'(head.map) == map_ff) && (4'(head.map) < 4'(NM))
                    && (cross_on || cross_off);
            down  = cross_on;
         end
         default: ;
      endcase
      do_emit = match && act_ok && (down != trig_ff[act_idx]);
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      map_in   = map_ff;
      hand_in  = hand_ff;
      pmod_in  = pmod_ff;
      trig_in  = trig_ff;
      shift    = 1'b0;
      ov_in    = ov_ff && !rsp_ready;
      od_in    = od_ff;
      case (state_ff)
         iam_pkg::ST_IDLE: begin
            step_in = '0;
            hand_in = 1'b0;
            if (req_valid) begin
               if ((req_data.cmd == iam_pkg::CMD_WR_BIND) ||
                   (req_data.cmd == iam_pkg::CMD_WR_MAP)) begin
                  state_in = iam_pkg::ST_IDLE;
               end else if (!en_ff) begin
                  state_in = iam_pkg::ST_FINAL;
               end else if ((req_data.cmd == iam_pkg::CMD_BTN_DOWN) ||
                            (req_data.cmd == iam_pkg::CMD_BTN_UP) ||
                            (req_data.cmd == iam_pkg::CMD_AXIS)) begin
                  state_in = iam_pkg::ST_SEARCH;
               end else begin
                  state_in = iam_pkg::ST_SCAN;
               end
            end
         end
         iam_pkg::ST_SEARCH: begin
            if (step_ff >= 9'(nmap_ff)) begin
               state_in = iam_pkg::ST_FINAL;
            end else if (ids_ff[MW'(step_ff)] == {ev_ff.vendor_id, ev_ff.product_id}) begin
               map_in   = MW'(step_ff);
               step_in  = '0;
               state_in = iam_pkg::ST_SCAN;
            end else begin
               step_in = step_ff + 9'd1;
            end
         end
         iam_pkg::ST_SCAN: begin
            // whole rotation always, so slot 0 is back at the head afterwards
            if (out_free) begin
               shift   = 1'b1;
               step_in = step_ff + 9'd1;
               if ((step_ff < nbind_ff) && match && act_ok) begin
                  hand_in = 1'b1;
               end
               if ((step_ff < nbind_ff) && do_emit) begin
                  trig_in[act_idx] = down;
                  ov_in = 1'b1;
                  od_in.event_kind = down ? iam_pkg::EV_DOWN : iam_pkg::EV_UP;
                  od_in.action     = head.action;
                  od_in.handled    = 1'b0;
                  od_in.last       = 1'b0;
               end
               if (step_ff == 9'(NB - 1)) begin
                  state_in = iam_pkg::ST_FINAL;
               end
            end
         end
         iam_pkg::ST_FINAL: begin
            if (out_free) begin
               ov_in = 1'b1;
               od_in.event_kind = iam_pkg::EV_FINAL;
               od_in.action     = '0;
               od_in.handled    = hand_ff && !is_mod;
               od_in.last       = 1'b1;
               if (is_mod) begin
                  pmod_in = ev_ff.modifier_mask;
               end
               state_in = iam_pkg::ST_IDLE;
            end
         end
         default: state_in = iam_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iam_pkg::ST_IDLE;
         step_ff  <= '0;
         hand_ff  <= 1'b0;
         pmod_ff  <= '0;
         trig_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         hand_ff  <= hand_in;
         pmod_ff  <= pmod_in;
         trig_ff  <= trig_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      od_ff  <= od_in;
      map_ff <= map_in;
      if (req_valid && req_ready) begin
         ev_ff <= req_data;
      end
   end
endmodule

>>> hw/rtl/iam_checker.sv
// ----------------------------------------------------------------------------
// Input action mapper port checker
// Watches the top level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module iam_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input iam_pkg::rsp_type rsp_data
);
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("req dropped before transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_final_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.event_kind == iam_pkg::EV_FINAL)
      else $error("final transfer with action kind");

   a_action_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !rsp_data.handled &&
      (rsp_data.event_kind == iam_pkg::EV_DOWN || rsp_data.event_kind == iam_pkg::EV_UP))
      else $error("bad action transfer");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("input taken mid run");
endmodule

bind input_action_mapper_top iam_checker u_iam_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
